/* sv/rti_pkg.sv */
// shared types and constants for the ray/triangle intersection pipeline
`default_nettype none
package rti_pkg;

	localparam int CW   = 21;   // coordinate field width
	localparam int EW   = 22;   // edge / difference width
	localparam int PW   = 44;   // width of one coordinate product
	localparam int BW   = 46;   // width of cross products and plane sums
	localparam int SPL  = 22;   // split point of the wide multiplier operand
	localparam int WW   = 70;   // width of dot products and divider words
	localparam int QW   = 22;   // quotient bits kept by the divider
	localparam int RIW  = 2;    // register index width
	localparam int RW   = 63;   // register width
	localparam int DW   = 128;  // tdata width

	localparam logic [RIW-1:0] REG_VERTEX_A    = 2'd0;
	localparam logic [RIW-1:0] REG_VERTEX_B    = 2'd1;
	localparam logic [RIW-1:0] REG_VERTEX_C    = 2'd2;
	localparam logic [RIW-1:0] REG_UNIT_NORMAL = 2'd3;

	typedef logic signed [CW-1:0] c21_t;
	typedef logic signed [EW-1:0] e22_t;
	typedef logic signed [PW-1:0] p44_t;
	typedef logic signed [BW-1:0] b46_t;
	typedef logic signed [WW-1:0] w70_t;
	typedef logic signed [CW+2:0] s24_t;

	localparam c21_t POS_MAX = 21'sh0FFFFF;
	localparam c21_t POS_MIN = 21'sh100000;

	// per-ray flags and origin that ride alongside the divider
	typedef struct packed {
		logic       hit;
		logic       den_zero;
		logic       den_pos;
		logic [2:0] neg;
		c21_t       ox;
		c21_t       oy;
		c21_t       oz;
	} side_t;

	function automatic c21_t slice21(input logic [RW-1:0] r, input int k);
		return c21_t'(r[k*CW +: CW]);
	endfunction

endpackage
`default_nettype wire

/* sv/ray_triangle_intersect.sv */
// ray/triangle intersection top level: config registers, pipeline and output register
// pipeline: 8 arithmetic stages, a 23-stage divider for the hit point and
// one output register
// throughput: one ray per cycle; the whole pipeline holds while a result waits
// reset clears all valid bits and the four triangle registers to zero
`default_nettype none
module ray_triangle_intersect import rti_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
	input  wire logic [DW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	// hit_x, hit_y, hit_z, facing_x, facing_y, facing_z, zero pad
	output logic [DW-1:0]       m_tdata,
	// hit
	output logic                m_tuser,
	input  wire logic           cfg_we,
	input  wire logic [RIW-1:0] cfg_addr,
	input  wire logic [RW-1:0]  cfg_wdata
);

	localparam int DIV_LAT = QW + 1;
	localparam int LAT     = 8 + DIV_LAT + 1;

	logic [RW-1:0]  va_q, vb_q, vc_q, vn_q;
	logic [LAT-1:0] vld_q;
	logic           en;

	c21_t va [3], vb [3], vc [3], vn [3];
	e22_t e1 [3], e2 [3];
	c21_t in_o [3], in_d [3];

	c21_t o_s1 [3], o_s2 [3], o_s3 [3], o_s4 [3], o_s5 [3], o_s6 [3], o_s7 [3];
	e22_t d_s1 [3], d_s2 [3], d_s3 [3];
	e22_t tv_s1 [3], tv_s2 [3], tv_s3 [3];
	e22_t bo_s1 [3];
	p44_t pa_s2 [3], pb_s2 [3], qa_s2 [3], qb_s2 [3], np_s2 [3], dp_s2 [3];
	b46_t pv_s3 [3], qv_s3 [3];
	b46_t num_s3, den_s3, den_s4, den_s5, den_s6;

	w70_t det_y, nu_y, nv_y, nt_y;
	w70_t p_y [3];
	e22_t pd_a [3][3];
	b46_t pd_b [3];

	w70_t den_w, dd_w;
	w70_t pn [3];
	logic dz_s7, den_zero_s7, den_pos_s7;
	w70_t det_s7, nu_s7, nv_s7, nt_s7, dd_s7;
	w70_t n_s7 [3];

	w70_t diff1, diff2, dv_w;
	logic miss;
	side_t side_s8;
	logic [WW-1:0] m_s8 [3];
	logic [WW-1:0] dv_s8;

	logic [QW-1:0] q_d [3];
	logic          ovf_d [3];
	side_t         side_q [0:DIV_LAT-1];
	side_t         sd;

	c21_t          pos [3], fac [3], ov [3];
	s24_t          qs, sum;
	logic [DW-1:0] data_nxt;
	logic [DW-1:0] data_q;
	logic          hit_q;

	assign m_tvalid = vld_q[LAT-1];
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tdata  = data_q;
	assign m_tuser  = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= '0;
			vb_q <= '0;
			vc_q <= '0;
			vn_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_VERTEX_A:    va_q <= cfg_wdata;
				REG_VERTEX_B:    vb_q <= cfg_wdata;
				REG_VERTEX_C:    vc_q <= cfg_wdata;
				REG_UNIT_NORMAL: vn_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i]   = slice21(va_q, i);
			vb[i]   = slice21(vb_q, i);
			vc[i]   = slice21(vc_q, i);
			vn[i]   = slice21(vn_q, i);
			e1[i]   = e22_t'(vb[i]) - e22_t'(va[i]);
			e2[i]   = e22_t'(vc[i]) - e22_t'(va[i]);
			in_o[i] = c21_t'(s_tdata[i*CW +: CW]);
			in_d[i] = c21_t'(s_tdata[(3+i)*CW +: CW]);
		end
	end

	// stage 1: vectors between the origin and vertices A and B
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				o_s1[i]  <= in_o[i];
				d_s1[i]  <= e22_t'(in_d[i]);
				tv_s1[i] <= e22_t'(in_o[i]) - e22_t'(va[i]);
				bo_s1[i] <= e22_t'(vb[i]) - e22_t'(in_o[i]);
			end
		end
	end

	// stage 2: products for both cross products and the plane sums
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2[0] <= d_s1[1] * e2[2];
			pb_s2[0] <= d_s1[2] * e2[1];
			pa_s2[1] <= d_s1[2] * e2[0];
			pb_s2[1] <= d_s1[0] * e2[2];
			pa_s2[2] <= d_s1[0] * e2[1];
			pb_s2[2] <= d_s1[1] * e2[0];
			qa_s2[0] <= tv_s1[1] * e1[2];
			qb_s2[0] <= tv_s1[2] * e1[1];
			qa_s2[1] <= tv_s1[2] * e1[0];
			qb_s2[1] <= tv_s1[0] * e1[2];
			qa_s2[2] <= tv_s1[0] * e1[1];
			qb_s2[2] <= tv_s1[1] * e1[0];
			for (int i = 0; i < 3; i++) begin
				np_s2[i] <= bo_s1[i] * e22_t'(vn[i]);
				dp_s2[i] <= d_s1[i] * e22_t'(vn[i]);
				o_s2[i]  <= o_s1[i];
				d_s2[i]  <= d_s1[i];
				tv_s2[i] <= tv_s1[i];
			end
		end
	end

	// stage 3: p and q vectors, plane numerator and denominator
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pv_s3[i] <= b46_t'(pa_s2[i]) - b46_t'(pb_s2[i]);
				qv_s3[i] <= b46_t'(qa_s2[i]) - b46_t'(qb_s2[i]);
				o_s3[i]  <= o_s2[i];
				d_s3[i]  <= d_s2[i];
				tv_s3[i] <= tv_s2[i];
			end
			num_s3 <= b46_t'(np_s2[0]) + b46_t'(np_s2[1]) + b46_t'(np_s2[2]);
			den_s3 <= b46_t'(dp_s2[0]) + b46_t'(dp_s2[1]) + b46_t'(dp_s2[2]);
		end
	end

	// stages 4 to 6: wide dot products
	rti_dot3 u_det (.clk(clk), .en(en), .a(e1),    .b(pv_s3), .y(det_y));
	rti_dot3 u_nu  (.clk(clk), .en(en), .a(tv_s3), .b(pv_s3), .y(nu_y));
	rti_dot3 u_nv  (.clk(clk), .en(en), .a(d_s3),  .b(qv_s3), .y(nv_y));
	rti_dot3 u_nt  (.clk(clk), .en(en), .a(e2),    .b(qv_s3), .y(nt_y));

	always_comb begin
		pd_b[0] = num_s3;
		pd_b[1] = '0;
		pd_b[2] = '0;
		for (int i = 0; i < 3; i++) begin
			pd_a[i][0] = d_s3[i];
			pd_a[i][1] = '0;
			pd_a[i][2] = '0;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_pnum
		rti_dot3 u_p (.clk(clk), .en(en), .a(pd_a[i]), .b(pd_b), .y(p_y[i]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_s4   <= o_s3;
			o_s5   <= o_s4;
			o_s6   <= o_s5;
			den_s4 <= den_s3;
			den_s5 <= den_s4;
			den_s6 <= den_s5;
		end
	end

	// stage 7: make the determinant and the plane denominator positive
	always_comb begin
		den_w = w70_t'(den_s6);
		dd_w  = den_w[WW-1] ? -den_w : den_w;
		for (int i = 0; i < 3; i++) begin
			pn[i] = den_w[WW-1] ? -p_y[i] : p_y[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_s7       <= det_y == '0;
			det_s7      <= det_y[WW-1] ? -det_y : det_y;
			nu_s7       <= det_y[WW-1] ? -nu_y : nu_y;
			nv_s7       <= det_y[WW-1] ? -nv_y : nv_y;
			nt_s7       <= det_y[WW-1] ? -nt_y : nt_y;
			dd_s7       <= dd_w;
			den_zero_s7 <= den_s6 == '0;
			den_pos_s7  <= !den_s6[BW-1] && den_s6 != '0;
			for (int i = 0; i < 3; i++) begin
				// doubled numerator plus divisor: rounds half up after the floor
				n_s7[i] <= (pn[i] <<< 1) + dd_w;
				o_s7[i] <= o_s6[i];
			end
		end
	end

	// stage 8: barycentric range test, divider operands
	always_comb begin
		diff1 = det_s7 - nu_s7;
		diff2 = diff1 - nv_s7;
		dv_w  = dd_s7 <<< 1;
		miss  = dz_s7 || nu_s7[WW-1] || diff1[WW-1] || nv_s7[WW-1] || diff2[WW-1]
			|| nt_s7[WW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8.hit      <= !miss;
			side_s8.den_zero <= den_zero_s7;
			side_s8.den_pos  <= den_pos_s7;
			side_s8.ox       <= o_s7[0];
			side_s8.oy       <= o_s7[1];
			side_s8.oz       <= o_s7[2];
			dv_s8            <= dv_w;
			for (int i = 0; i < 3; i++) begin
				side_s8.neg[i] <= n_s7[i][WW-1];
				// floor of a negative ratio: divide the magnitude rounded up
				m_s8[i] <= n_s7[i][WW-1] ? (dv_w - w70_t'(1) - n_s7[i]) : n_s7[i];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		rti_div u_div (
			.clk(clk), .en(en), .m(m_s8[i]), .dv(dv_s8), .q(q_d[i]), .ovf(ovf_d[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s8;
			for (int j = 1; j < DIV_LAT; j++) begin
				side_q[j] <= side_q[j-1];
			end
		end
	end

	// final stage: sign, add origin, saturate, orient the normal
	always_comb begin
		sd    = side_q[DIV_LAT-1];
		ov[0] = sd.ox;
		ov[1] = sd.oy;
		ov[2] = sd.oz;
		qs    = '0;
		sum   = '0;
		for (int i = 0; i < 3; i++) begin
			qs  = sd.neg[i] ? (s24_t'(0) - s24_t'(q_d[i])) : s24_t'(q_d[i]);
			sum = s24_t'(ov[i]) + qs;
			if (sd.den_zero) begin
				pos[i] = ov[i];
			end else if (ovf_d[i]) begin
				pos[i] = sd.neg[i] ? POS_MIN : POS_MAX;
			end else if (sum > s24_t'(POS_MAX)) begin
				pos[i] = POS_MAX;
			end else if (sum < s24_t'(POS_MIN)) begin
				pos[i] = POS_MIN;
			end else begin
				pos[i] = c21_t'(sum);
			end
			if (sd.den_pos) begin
				fac[i] = (vn[i] == POS_MIN) ? POS_MAX : -vn[i];
			end else begin
				fac[i] = vn[i];
			end
		end
		if (sd.hit) begin
			data_nxt = {2'b00, fac[2], fac[1], fac[0], pos[2], pos[1], pos[0]};
		end else begin
			data_nxt = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= data_nxt;
			hit_q  <= sd.hit;
		end
	end

`ifndef ASSERT_OFF
	a_miss_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss result carries nonzero fields");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_hold_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during stall");
`endif

endmodule
`default_nettype wire

/* sv/rti_dot3.sv */
// three-stage dot product of 22-bit by 46-bit signed vectors, split multipliers
`default_nettype none
module rti_dot3 import rti_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire e22_t a [3],
	input  wire b46_t b [3],
	output w70_t      y
);

	logic signed [EW+SPL:0]      lo_s1 [3];
	logic signed [EW+BW-SPL-1:0] hi_s1 [3];
	w70_t                        prod_s2 [3];
	w70_t                        y_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				lo_s1[i] <= a[i] * $signed({1'b0, b[i][SPL-1:0]});
				hi_s1[i] <= a[i] * $signed(b[i][BW-1:SPL]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= (w70_t'(hi_s1[i]) <<< SPL) + w70_t'(lo_s1[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s3 <= prod_s2[0] + prod_s2[1] + prod_s2[2];
		end
	end

	assign y = y_s3;

endmodule
`default_nettype wire

/* sv/rti_div.sv */
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none
module rti_div import rti_pkg::*; (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [WW-1:0] m,
	input  wire logic [WW-1:0] dv,
	output logic [QW-1:0]      q,
	output logic               ovf
);

	logic [WW-1:0] rem_q [0:QW-1];
	logic [WW-1:0] dv_q  [0:QW-1];
	logic [QW-1:0] quo_q [0:QW];
	logic          ovf_q [0:QW];

	// quotient too large for the kept bits: result saturates anyway
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= m;
			dv_q[0]  <= dv;
			quo_q[0] <= '0;
			ovf_q[0] <= m >= (dv << QW);
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [WW-1:0] sh;
		logic          take;

		assign sh   = dv_q[j] << K;
		assign take = rem_q[j] >= sh;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[j+1] <= take ? (quo_q[j] | (QW'(1) << K)) : quo_q[j];
				ovf_q[j+1] <= ovf_q[j];
			end
		end

		if (j < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j+1] <= take ? (rem_q[j] - sh) : rem_q[j];
					dv_q[j+1]  <= dv_q[j];
				end
			end
		end
	end

	assign q   = quo_q[QW];
	assign ovf = ovf_q[QW];

endmodule
`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the ray/triangle intersection pipeline
`default_nettype none
module testbench;
	import rti_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] wide_t;

	// packed so that ox sits in the lowest bits
	typedef struct packed {
		c21_t dz, dy, dx, oz, oy, ox;
	} ray_t;

	typedef struct packed {
		logic hit;
		c21_t fz, fy, fx, hz, hy, hx;
	} isect_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [DW-1:0]    s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [DW-1:0]    m_tdata;
	logic             m_tuser;
	logic             cfg_we = 1'b0;
	logic [RIW-1:0]   cfg_addr = '0;
	logic [RW-1:0]    cfg_wdata = '0;

	ray_t   ray_q[$];
	isect_t isect_q[$];
	logic [RW-1:0] tri_regs[4];
	longint ta[3], tb[3], tc[3];

	bit     in_taken, quiet, hold_req;
	int     send_gap, recv_stall, hold_cnt;
	int     mismatches, n_results, n_hits;

	ray_triangle_intersect i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic wide_t wmul(longint x, longint y);
		return wide_t'(x) * wide_t'(y);
	endfunction

	function automatic void cross3(input longint p[3], input longint q[3], output longint r[3]);
		r[0] = p[1] * q[2] - p[2] * q[1];
		r[1] = p[2] * q[0] - p[0] * q[2];
		r[2] = p[0] * q[1] - p[1] * q[0];
	endfunction

	function automatic wide_t dot3(input longint p[3], input longint q[3]);
		return wmul(p[0], q[0]) + wmul(p[1], q[1]) + wmul(p[2], q[2]);
	endfunction

	function automatic void split3(input logic [RW-1:0] r, output longint v[3]);
		for (int k = 0; k < 3; k++)
			v[k] = longint'(c21_t'(r[k*CW +: CW]));
	endfunction

	function automatic isect_t trace_ray(ray_t ray);
		longint o[3], d[3], a[3], b[3], c[3], n[3];
		longint e1[3], e2[3], tv[3], pv[3], qv[3];
		longint num, den, dd, pos[3], fac[3];
		wide_t det, nu, nv, nt, p, q, dv;
		isect_t r;
		r = '0;
		o = '{longint'(ray.ox), longint'(ray.oy), longint'(ray.oz)};
		d = '{longint'(ray.dx), longint'(ray.dy), longint'(ray.dz)};
		split3(tri_regs[REG_VERTEX_A], a);
		split3(tri_regs[REG_VERTEX_B], b);
		split3(tri_regs[REG_VERTEX_C], c);
		split3(tri_regs[REG_UNIT_NORMAL], n);
		for (int k = 0; k < 3; k++) begin
			e1[k] = b[k] - a[k];
			e2[k] = c[k] - a[k];
			tv[k] = o[k] - a[k];
		end
		cross3(d, e2, pv);
		det = dot3(e1, pv);
		if (det == 0) return r;
		cross3(tv, e1, qv);
		nu = dot3(tv, pv);
		nv = dot3(d, qv);
		nt = dot3(e2, qv);
		if (det < 0) begin
			det = -det; nu = -nu; nv = -nv; nt = -nt;
		end
		if (nu < 0 || nu > det || nv < 0 || nu + nv > det || nt < 0) return r;
		num = 0;
		den = 0;
		for (int k = 0; k < 3; k++) begin
			num += (b[k] - o[k]) * n[k];
			den += d[k] * n[k];
		end
		for (int k = 0; k < 3; k++) begin
			if (den == 0) begin
				pos[k] = o[k];
			end else begin
				p = wmul(num, d[k]);
				dd = den;
				if (dd < 0) begin
					p = -p;
					dd = -dd;
				end
				p = 2 * p + wide_t'(dd);
				dv = 2 * wide_t'(dd);
				// floor division, ties of the rounding go up
				if (p >= 0) q = p / dv;
				else q = -((-p + dv - 1) / dv);
				q = q + wide_t'(o[k]);
				if (q < -1048576) pos[k] = -1048576;
				else if (q > 1048575) pos[k] = 1048575;
				else pos[k] = longint'(q);
			end
			if (den > 0) fac[k] = (n[k] == -1048576) ? 1048575 : -n[k];
			else fac[k] = n[k];
		end
		r.hit = 1'b1;
		r.hx = c21_t'(pos[0]); r.hy = c21_t'(pos[1]); r.hz = c21_t'(pos[2]);
		r.fx = c21_t'(fac[0]); r.fy = c21_t'(fac[1]); r.fz = c21_t'(fac[2]);
		return r;
	endfunction

	// input side
	always @(posedge clk) begin
		in_taken = s_tvalid && s_tready;
		if (in_taken)
			isect_q.push_back(trace_ray(ray_t'(s_tdata[6*CW-1:0])));
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (ray_q.size() > 0) begin
				s_tdata <= {{(DW-6*CW){1'b0}}, ray_q.pop_front()};
				s_tvalid <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 10);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 300;
			m_tready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			recv_stall = $urandom_range(1, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	always @(posedge clk) begin
		isect_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[6*CW-1:0]};
			n_results++;
			if (isect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = isect_q.pop_front();
				if (want.hit) n_hits++;
				if (got.hit !== want.hit) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d hit: expected %b got %b", n_results, want.hit, got.hit);
				end
				for (int k = 0; k < 6; k++) begin
					if (got[k*CW +: CW] !== want[k*CW +: CW]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d field %0d: expected %0d got %0d", n_results, k,
								c21_t'(want[k*CW +: CW]), c21_t'(got[k*CW +: CW]));
					end
				end
			end
		end
	end

	task automatic write_reg(logic [RIW-1:0] idx, logic [RW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		tri_regs[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [RW-1:0] pack3(longint x, longint y, longint z);
		return {c21_t'(z), c21_t'(y), c21_t'(x)};
	endfunction

	// vertices and a unit normal worked out from them
	task automatic set_triangle(longint a[3], longint b[3], longint c[3]);
		longint e1[3], e2[3], cr[3];
		real len, comp;
		longint nq[3];
		ta = a; tb = b; tc = c;
		for (int k = 0; k < 3; k++) begin
			e1[k] = b[k] - a[k];
			e2[k] = c[k] - a[k];
		end
		cross3(e1, e2, cr);
		len = $sqrt(real'(cr[0]) ** 2 + real'(cr[1]) ** 2 + real'(cr[2]) ** 2);
		for (int k = 0; k < 3; k++) begin
			comp = (len == 0.0) ? 0.0 : real'(cr[k]) / len * 524288.0;
			nq[k] = $rtoi(comp + (comp >= 0.0 ? 0.5 : -0.5));
			if (nq[k] > 1048575) nq[k] = 1048575;
			if (nq[k] < -1048575) nq[k] = -1048575;
		end
		write_reg(REG_VERTEX_A, pack3(a[0], a[1], a[2]));
		write_reg(REG_VERTEX_B, pack3(b[0], b[1], b[2]));
		write_reg(REG_VERTEX_C, pack3(c[0], c[1], c[2]));
		write_reg(REG_UNIT_NORMAL, pack3(nq[0], nq[1], nq[2]));
	endtask

	function automatic ray_t mk_ray(longint ox, oy, oz, dx, dy, dz);
		ray_t r;
		r.ox = c21_t'(ox); r.oy = c21_t'(oy); r.oz = c21_t'(oz);
		r.dx = c21_t'(dx); r.dy = c21_t'(dy); r.dz = c21_t'(dz);
		return r;
	endfunction

	function automatic longint rnd_span(int span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	// ray aimed at a point inside the current triangle, sometimes reversed or halved
	function automatic ray_t aimed_ray(int span);
		longint o[3], tgt[3], d[3];
		int ui, vi;
		ui = $urandom_range(0, 1024);
		vi = $urandom_range(0, 1024 - ui);
		for (int k = 0; k < 3; k++) begin
			tgt[k] = ta[k] + ((tb[k] - ta[k]) * ui + (tc[k] - ta[k]) * vi) / 1024;
			o[k] = rnd_span(span);
			d[k] = tgt[k] - o[k];
		end
		case ($urandom_range(0, 9))
			0: for (int k = 0; k < 3; k++) d[k] = -d[k];
			1, 2: for (int k = 0; k < 3; k++) d[k] = d[k] / 2;
			default: ;
		endcase
		return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
	endfunction

	function automatic ray_t noise_ray();
		return ray_t'({$urandom, $urandom, $urandom, $urandom});
	endfunction

	// checked at the rising edge, where the driver's last update has settled
	task automatic drain();
		while (ray_q.size() > 0 || s_tvalid || isect_q.size() > 0 || hold_cnt > 0)
			@(posedge clk);
		repeat (40) @(negedge clk);
	endtask

	initial begin
		longint a[3], b[3], c[3];
		int span;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		tri_regs = '{default: '0};

		// registers at reset: degenerate triangle, every ray misses
		ray_q.push_back(mk_ray(-1048576, -1048576, -1048576, -1048576, -1048576, -1048576));
		ray_q.push_back(mk_ray(1048575, 1048575, 1048575, 1048575, 1048575, 1048575));
		ray_q.push_back(mk_ray(0, 0, 1024, 0, 0, -1024));
		drain();

		set_triangle('{0, 0, 0}, '{4096, 0, 0}, '{0, 4096, 0});
		ray_q.push_back(mk_ray(1024, 1024, 4096, 0, 0, -1024));   // interior hit
		ray_q.push_back(mk_ray(1024, 1024, -4096, 0, 0, 1024));   // from below, normal flips
		ray_q.push_back(mk_ray(0, 0, 1024, 0, 0, -1));            // on a vertex
		ray_q.push_back(mk_ray(2048, 2048, 1024, 0, 0, -2048));   // on the far edge
		ray_q.push_back(mk_ray(4096, 0, 1024, 0, 0, -1024));      // on the other vertex
		ray_q.push_back(mk_ray(1024, 1024, 4096, 0, 0, 1024));    // behind origin
		ray_q.push_back(mk_ray(1024, 1024, 0, 1024, 0, 0));       // parallel, det zero
		ray_q.push_back(mk_ray(1024, 1024, 0, 0, 0, 0));          // zero direction
		ray_q.push_back(mk_ray(5000, 5000, 1024, 0, 0, -1024));   // outside
		ray_q.push_back(mk_ray(-1048576, -1048576, 1048575, 1048575, 1048575, -1048576));
		ray_q.push_back(mk_ray(1024, 1024, 1048575, 0, 0, -1048576));
		drain();

		// normal inconsistent with the triangle: parallel plane, then a saturating flip
		write_reg(REG_UNIT_NORMAL, pack3(524288, 0, 0));
		ray_q.push_back(mk_ray(1024, 1024, 4096, 0, 0, -1024));
		drain();
		write_reg(REG_UNIT_NORMAL, pack3(-1048576, -1048576, -1048576));
		ray_q.push_back(mk_ray(1024, 1024, 4096, 0, 0, -1024));
		ray_q.push_back(mk_ray(1024, 1024, 4096, 1, 0, -1024));
		ray_q.push_back(mk_ray(1024, 1024, -4096, 1, 1, 1024));
		drain();

		// extreme vertices
		set_triangle('{-1048576, -1048576, 0}, '{1048575, -1048576, 0}, '{-1048576, 1048575, 0});
		ray_q.push_back(mk_ray(-1024, -1024, 1048575, 0, 0, -1048576));
		ray_q.push_back(mk_ray(-1048576, -1048576, -1048576, 0, 0, 1048575));
		ray_q.push_back(mk_ray(1048575, 1048575, 1024, 0, 0, -1));
		for (int k = 0; k < 20; k++) ray_q.push_back(noise_ray());
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			span = (ph % 3 == 0) ? 4096 : (ph % 3 == 1) ? 65536 : 524287;
			for (int k = 0; k < 3; k++) begin
				a[k] = rnd_span(span);
				b[k] = rnd_span(span);
				c[k] = rnd_span(span);
			end
			set_triangle(a, b, c);
			if (ph == 4) write_reg(REG_UNIT_NORMAL, {$urandom, $urandom});
			if (ph == 5) write_reg(REG_UNIT_NORMAL, '0);
			if (ph == 2) hold_req = 1'b1;
			if (ph == 8) quiet = 1'b1;
			for (int k = 0; k < 110; k++) begin
				if ($urandom_range(0, 3) == 0) ray_q.push_back(noise_ray());
				else ray_q.push_back(aimed_ray(span));
			end
			drain();
		end

		$display("%0d rays checked, %0d hits, over degenerate, extreme, inconsistent-normal",
			n_results, n_hits);
		$display("and random triangles with aimed and noise rays, %0d mismatches", mismatches);
		if (mismatches == 0 && isect_q.size() == 0) begin
			$display("ray_triangle_intersect test passed");
		end else begin
			$display("ray_triangle_intersect test failed");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("ray_triangle_intersect test failed");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
sv/rti_pkg.sv
sv/rti_dot3.sv
sv/rti_div.sv
sv/ray_triangle_intersect.sv
tb/testbench.sv
